/* hw/rtl/bpa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, codes and types of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int PAGE_BITS  = 14;
  localparam int TOP_ORDER  = 10;
  localparam int EFF_TOP    = (TOP_ORDER < PAGE_BITS) ? TOP_ORDER : PAGE_BITS;
  localparam int NUM_ORDERS = EFF_TOP + 1;
  localparam int ORD_W      = 4;
  localparam int CNT_W      = PAGE_BITS + 1;
  // bit position within the free map, all orders laid end to end
  localparam int MAP_AW     = PAGE_BITS + 1;
  localparam int BIT_AW     = 5;
  localparam int WORD_BITS  = 32;
  localparam int MEM_AW     = MAP_AW - BIT_AW;
  localparam int MEM_DEPTH  = 1 << MEM_AW;

  localparam logic       OP_ALLOC   = 1'b0;
  localparam logic       OP_FREE    = 1'b1;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LOW     = 2'd1;
  localparam logic [1:0] ST_NOFREE  = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;
  localparam logic [1:0] CLS_MIN    = 2'd0;
  localparam logic [1:0] CLS_LOW    = 2'd1;
  localparam logic [1:0] REG_WM_MIN  = 2'd0;
  localparam logic [1:0] REG_WM_LOW  = 2'd1;
  localparam logic [1:0] REG_WM_HIGH = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] wm_min;
    logic [CNT_W-1:0] wm_low;
    logic [CNT_W-1:0] wm_high;
  } wm_t;

  typedef struct packed {
    logic                 operation;
    logic [3:0]           block_order;
    logic [PAGE_BITS-1:0] page_index;
    logic [1:0]           watermark_class;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [PAGE_BITS-1:0] block_index;
    logic [CNT_W-1:0]     pages_left;
  } rsp_t;

  typedef struct packed {
    logic                 rd_en;
    logic                 wr_en;
    logic [MEM_AW-1:0]    addr;
    logic [WORD_BITS-1:0] wdata;
  } map_req_t;

  // first map position of the blocks of order k
  function automatic logic [MAP_AW-1:0] map_off(input logic [ORD_W-1:0] k);
    logic [MAP_AW:0] full;
    logic [MAP_AW:0] tail;
    full = (MAP_AW + 1)'(1) << MAP_AW;
    tail = (MAP_AW + 1)'(1) << (MAP_AW - int'(k));
    return MAP_AW'(full - tail);
  endfunction

endpackage

/* hw/rtl/bpa_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_req_if
// Request channel: valid/ready with one allocate or free request.
// ----------------------------------------------------------------------------
interface bpa_req_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [3:0]                    block_order;
  logic [bpa_pkg::PAGE_BITS-1:0] page_index;
  logic [1:0]                    watermark_class;

  modport source (output valid, operation, block_order, page_index, watermark_class,
                  input ready);
  modport sink   (input valid, operation, block_order, page_index, watermark_class,
                  output ready);
endinterface

/* hw/rtl/bpa_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_rsp_if
// Result channel: valid/ready with status, block index and free page count.
// ----------------------------------------------------------------------------
interface bpa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [bpa_pkg::PAGE_BITS-1:0] block_index;
  logic [bpa_pkg::CNT_W-1:0]     pages_left;

  modport source (output valid, status, block_index, pages_left, input ready);
  modport sink   (input valid, status, block_index, pages_left, output ready);
endinterface

/* hw/rtl/bpa_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bpa_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                index;
  logic [bpa_pkg::CNT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/bpa_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_map
// Free map store: one bit per block of every order, 32 bits to a word,
// one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module bpa_map (
  input  logic                                clk,
  input  bpa_pkg::map_req_t                   req,
  output logic [bpa_pkg::WORD_BITS-1:0]       rdata
);

  logic [bpa_pkg::WORD_BITS-1:0] mem [bpa_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

/* hw/rtl/bpa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ctrl
// Request sequencer: watermark test, free map scans, split and merge
// read-modify-write steps, per-order counts and the free page count.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  bpa_pkg::req_t                 req,
  input  bpa_pkg::wm_t                  wm,
  input  logic                          slot_free,
  output logic                          idle,
  output logic                          done,
  output bpa_pkg::rsp_t                 rsp,
  output bpa_pkg::map_req_t             mreq,
  input  logic [bpa_pkg::WORD_BITS-1:0] rdata
);

  localparam int PB  = bpa_pkg::PAGE_BITS;
  localparam int TOP = bpa_pkg::EFF_TOP;
  localparam int AW  = bpa_pkg::MAP_AW;
  localparam int BW  = bpa_pkg::BIT_AW;
  localparam int MW  = bpa_pkg::MEM_AW;
  localparam int OW  = bpa_pkg::ORD_W;
  localparam int CW  = bpa_pkg::CNT_W;
  localparam int WB  = bpa_pkg::WORD_BITS;
  localparam logic [OW-1:0] TOP_K = OW'(TOP);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_ORD, S_F_NEXT, S_SCAN, S_MRG_RD, S_MRG_CHK,
    S_SET_RD, S_SET_WR, S_DONE
  } state_t;

  state_t          state;
  logic [MW-1:0]   clr_w;
  logic            op;
  logic [OW-1:0]   order;
  logic [OW-1:0]   k;
  logic [OW-1:0]   jj;
  logic [PB-1:0]   idx;
  logic [MW-1:0]   w;
  logic [MW-1:0]   last_w;
  logic [AW-1:0]   lo;
  logic [AW:0]     hi;
  logic [AW-1:0]   rpos;
  logic [CW-1:0]   cnt [bpa_pkg::NUM_ORDERS];
  logic [CW-1:0]   fpc;
  logic [1:0]      status;
  logic [PB-1:0]   res_idx;

  // map word at reset: top-order blocks free
  function automatic logic [WB-1:0] init_word(input logic [MW-1:0] a);
    logic [WB-1:0] v;
    logic [AW-1:0] p;
    logic [AW:0]   top_hi;
    top_hi = {1'b0, bpa_pkg::map_off(TOP_K)} + ((AW + 1)'(1) << (PB - TOP));
    for (int i = 0; i < WB; i++) begin
      p    = {a, BW'(i)};
      v[i] = (p >= bpa_pkg::map_off(TOP_K)) && ({1'b0, p} < top_hi);
    end
    return v;
  endfunction

  logic [CW-1:0]   cnt_k;
  logic [AW-1:0]   lo_c;
  logic [AW:0]     hi_c;
  logic [AW-1:0]   base_f;
  logic [AW:0]     span_f;
  logic [WB-1:0]   masked;
  logic            hit;
  logic [BW-1:0]   fb;
  logic [AW-1:0]   found_blk;
  logic [PB-1:0]   found_idx;
  logic [AW-1:0]   mrg_pos;
  logic [AW-1:0]   set_pos;
  logic [PB-1:0]   set_blk;
  logic            rbit;
  logic [WB-1:0]   rmask;
  logic [CW-1:0]   wm_sel;
  logic [CW:0]     need;
  logic [PB-1:0]   align_mask;
  logic [CW-1:0]   size_pages;

  always_comb begin
    cnt_k = (k <= TOP_K) ? cnt[k] : '0;

    // scan window: a whole order on allocate, the overlap window on free
    base_f = AW'(idx >> jj);
    span_f = (jj >= order) ? (AW + 1)'(1) : ((AW + 1)'(1) << (order - jj));
    if (op == bpa_pkg::OP_ALLOC) begin
      lo_c = bpa_pkg::map_off(k);
      hi_c = {1'b0, lo_c} + ((AW + 1)'(1) << (PB - int'(k)));
    end else begin
      lo_c = bpa_pkg::map_off(jj) + base_f;
      hi_c = {1'b0, lo_c} + span_f;
    end

    for (int i = 0; i < WB; i++) begin
      masked[i] = rdata[i] && ({w, BW'(i)} >= lo) && ({1'b0, w, BW'(i)} < hi);
    end
    hit = |masked;
    fb  = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (masked[i]) fb = BW'(i);
    end
    found_blk = {w, fb} - bpa_pkg::map_off(k);
    found_idx = PB'(found_blk << k);

    mrg_pos = bpa_pkg::map_off(k) + AW'((idx >> k) ^ PB'(1));
    set_blk = (op == bpa_pkg::OP_ALLOC) ? ((idx >> k) | PB'(1)) : (idx >> k);
    set_pos = bpa_pkg::map_off(k) + AW'(set_blk);
    rmask   = WB'(1) << rpos[BW-1:0];
    rbit    = |(rdata & rmask);

    case (req.watermark_class)
      bpa_pkg::CLS_MIN: wm_sel = wm.wm_min;
      bpa_pkg::CLS_LOW: wm_sel = wm.wm_low;
      default:          wm_sel = wm.wm_high;
    endcase
    need       = {1'b0, wm_sel} + ((CW + 1)'(1) << req.block_order);
    align_mask = PB'((PB + 1)'(1) << req.block_order) - PB'(1);
    size_pages = CW'((CW + 1)'(1) << order);
  end

  always_comb begin
    mreq = '0;
    case (state)
      S_CLEAR: begin
        mreq.wr_en = 1'b1;
        mreq.addr  = clr_w;
        mreq.wdata = init_word(clr_w);
      end
      S_A_ORD: begin
        mreq.rd_en = (k <= TOP_K) && (cnt_k != '0);
        mreq.addr  = lo_c[AW-1:BW];
      end
      S_F_NEXT: begin
        mreq.rd_en = 1'b1;
        mreq.addr  = lo_c[AW-1:BW];
      end
      S_SCAN: begin
        if (hit && op == bpa_pkg::OP_ALLOC) begin
          mreq.wr_en = 1'b1;
          mreq.addr  = w;
          mreq.wdata = rdata & ~(WB'(1) << fb);
        end else if (!hit && w != last_w) begin
          mreq.rd_en = 1'b1;
          mreq.addr  = w + MW'(1);
        end
      end
      S_MRG_RD: begin
        mreq.rd_en = (k != TOP_K);
        mreq.addr  = mrg_pos[AW-1:BW];
      end
      S_MRG_CHK: begin
        mreq.wr_en = rbit;
        mreq.addr  = rpos[AW-1:BW];
        mreq.wdata = rdata & ~rmask;
      end
      S_SET_RD: begin
        mreq.rd_en = 1'b1;
        mreq.addr  = set_pos[AW-1:BW];
      end
      S_SET_WR: begin
        mreq.wr_en = 1'b1;
        mreq.addr  = rpos[AW-1:BW];
        mreq.wdata = rdata | rmask;
      end
      default: mreq = '0;
    endcase
  end

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE) && slot_free;
  assign rsp  = '{status: status, block_index: res_idx, pages_left: fpc};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_w <= '0;
      fpc   <= CW'(1) << PB;
      for (int i = 0; i < bpa_pkg::NUM_ORDERS; i++) begin
        cnt[i] <= (i == TOP) ? (CW'(1) << (PB - TOP)) : '0;
      end
    end else begin
      case (state)
        S_CLEAR: begin
          clr_w <= clr_w + MW'(1);
          if (clr_w == MW'(bpa_pkg::MEM_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            op      <= req.operation;
            order   <= req.block_order;
            k       <= req.block_order;
            jj      <= '0;
            idx     <= req.page_index;
            res_idx <= '0;
            if (req.block_order > TOP_K) begin
              status <= bpa_pkg::ST_BAD;
              state  <= S_DONE;
            end else if (req.operation == bpa_pkg::OP_ALLOC) begin
              if ({1'b0, fpc} < need) begin
                status <= bpa_pkg::ST_LOW;
                state  <= S_DONE;
              end else begin
                state <= S_A_ORD;
              end
            end else if ((req.page_index & align_mask) != '0) begin
              status <= bpa_pkg::ST_BAD;
              state  <= S_DONE;
            end else begin
              state <= S_F_NEXT;
            end
          end
        end
        S_A_ORD: begin
          if (k > TOP_K) begin
            status <= bpa_pkg::ST_NOFREE;
            state  <= S_DONE;
          end else if (cnt_k == '0) begin
            k <= k + OW'(1);
          end else begin
            lo     <= lo_c;
            hi     <= hi_c;
            w      <= lo_c[AW-1:BW];
            last_w <= MW'((hi_c - (AW + 1)'(1)) >> BW);
            state  <= S_SCAN;
          end
        end
        S_F_NEXT: begin
          lo     <= lo_c;
          hi     <= hi_c;
          w      <= lo_c[AW-1:BW];
          last_w <= MW'((hi_c - (AW + 1)'(1)) >> BW);
          state  <= S_SCAN;
        end
        S_SCAN: begin
          if (hit) begin
            if (op == bpa_pkg::OP_ALLOC) begin
              cnt[k] <= cnt[k] - CW'(1);
              idx    <= found_idx;
              if (k == order) begin
                fpc     <= fpc - size_pages;
                res_idx <= found_idx;
                status  <= bpa_pkg::ST_OK;
                state   <= S_DONE;
              end else begin
                k     <= k - OW'(1);
                state <= S_SET_RD;
              end
            end else begin
              status <= bpa_pkg::ST_BAD;
              state  <= S_DONE;
            end
          end else if (w != last_w) begin
            w <= w + MW'(1);
          end else if (op == bpa_pkg::OP_ALLOC) begin
            k     <= k + OW'(1);
            state <= S_A_ORD;
          end else if (jj == TOP_K) begin
            state <= S_MRG_RD;
          end else begin
            jj    <= jj + OW'(1);
            state <= S_F_NEXT;
          end
        end
        S_MRG_RD: begin
          rpos  <= mrg_pos;
          state <= (k == TOP_K) ? S_SET_RD : S_MRG_CHK;
        end
        S_MRG_CHK: begin
          if (rbit) begin
            cnt[k] <= cnt[k] - CW'(1);
            idx    <= idx & ~(PB'(1) << k);
            k      <= k + OW'(1);
            state  <= S_MRG_RD;
          end else begin
            state <= S_SET_RD;
          end
        end
        S_SET_RD: begin
          rpos  <= set_pos;
          state <= S_SET_WR;
        end
        S_SET_WR: begin
          if (!rbit) cnt[k] <= cnt[k] + CW'(1);
          if (op == bpa_pkg::OP_FREE) begin
            fpc    <= fpc + size_pages;
            status <= bpa_pkg::ST_OK;
            state  <= S_DONE;
          end else if (k == order) begin
            fpc     <= fpc - size_pages;
            res_idx <= idx;
            status  <= bpa_pkg::ST_OK;
            state   <= S_DONE;
          end else begin
            k     <= k - OW'(1);
            state <= S_SET_RD;
          end
        end
        S_DONE: begin
          if (slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/buddy_page_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Binary buddy allocator over one zone of pages, free map held in memory.
// ----------------------------------------------------------------------------
// Requests arrive on req (allocate or free), one result per request leaves on
// rsp, watermarks are written on cfg (always ready, index 0 min, 1 low,
// 2 high). One request is worked on at a time; ready on req is high whenever
// the sequencer is idle, even while a result still waits in the output
// register.
// A request rejected up front does not touch the map. An allocate looks at
// each order from the requested one up, skips orders with no free block and
// scans the map words of the others (up to 512 words at order 0, halving with
// each order, one word from order 9 up), then reads and writes the map once
// per split. A free scans the overlap windows of all orders, which span 11
// words at order 0, rising to 68 at order 10, and then checks buddies up to
// the top order. Every map access goes to the single-port free map memory.
// After reset a clearing pass writes all 1024 words of the initial free map;
// req is not ready during it, cfg writes are taken. When rsp stalls, a
// finished request holds in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module buddy_page_allocator (
  input  logic      clk,
  input  logic      rst,
  bpa_req_if.sink   req,
  bpa_rsp_if.source rsp,
  bpa_cfg_if.sink   cfg
);

  bpa_pkg::wm_t                  wm;
  bpa_pkg::req_t                 req_s;
  bpa_pkg::rsp_t                 res;
  bpa_pkg::map_req_t             mreq;
  logic [bpa_pkg::WORD_BITS-1:0] rdata;
  logic                          idle;
  logic                          done;
  logic                          out_valid;
  logic                          slot_free;

  assign req_s = '{operation: req.operation, block_order: req.block_order,
                   page_index: req.page_index, watermark_class: req.watermark_class};
  assign req.ready = idle;
  assign cfg.ready = 1'b1;
  assign slot_free = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wm.wm_min  <= bpa_pkg::CNT_W'(819);
      wm.wm_low  <= bpa_pkg::CNT_W'(1638);
      wm.wm_high <= bpa_pkg::CNT_W'(2457);
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          bpa_pkg::REG_WM_MIN:  wm.wm_min  <= cfg.data;
          bpa_pkg::REG_WM_LOW:  wm.wm_low  <= cfg.data;
          bpa_pkg::REG_WM_HIGH: wm.wm_high <= cfg.data;
          default: ;
        endcase
      end
      // load a finished result, drop one that has been transferred
      if (done) begin
        out_valid       <= 1'b1;
        rsp.status      <= res.status;
        rsp.block_index <= res.block_index;
        rsp.pages_left  <= res.pages_left;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (req.valid && idle),
    .req       (req_s),
    .wm        (wm),
    .slot_free (slot_free),
    .idle      (idle),
    .done      (done),
    .rsp       (res),
    .mreq      (mreq),
    .rdata     (rdata)
  );

  bpa_map u_map (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the buddy page allocator. A behavioural copy of the
// free map predicts status, block index and free page count for every
// request; results are checked in order against the predicted queue, under
// random idling and result stalls and across several watermark settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ZONE_PAGES = 1 << bpa_pkg::PAGE_BITS;
  localparam int TOP        = bpa_pkg::EFF_TOP;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE     = 200;

  typedef struct {
    int idx;
    int ord;
  } held_blk_t;

  // in-order store of predicted results
  class result_board;
    bpa_pkg::rsp_t pending[$];

    function void note(bpa_pkg::rsp_t exp_rsp);
      pending.push_back(exp_rsp);
    endfunction

    function string check(bpa_pkg::rsp_t got);
      bpa_pkg::rsp_t exp_rsp;
      if (pending.size() == 0) return "result with nothing predicted";
      exp_rsp = pending.pop_front();
      if (got.status !== exp_rsp.status)
        return $sformatf("status %0d, predicted %0d", got.status, exp_rsp.status);
      if (got.block_index !== exp_rsp.block_index)
        return $sformatf("block_index %0d, predicted %0d", got.block_index,
                         exp_rsp.block_index);
      if (got.pages_left !== exp_rsp.pages_left)
        return $sformatf("pages_left %0d, predicted %0d", got.pages_left,
                         exp_rsp.pages_left);
      return "";
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  bpa_req_if req ();
  bpa_rsp_if rsp ();
  bpa_cfg_if cfg ();

  buddy_page_allocator dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source),
    .cfg (cfg.sink)
  );

  always #4 clk = ~clk;

  result_board board = new();
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          results_seen = 0;
  int          status_seen [4];
  bit          calm = 1'b0;

  // predicted allocator state
  bit          free_bit [0:TOP][0:ZONE_PAGES-1];
  int          blocks_at [0:TOP];
  int          pages_free;
  logic [14:0] wmark [3];
  held_blk_t   held [$];

  task automatic report(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic void mark(input int k, input int b, input bit v);
    if (v && !free_bit[k][b]) blocks_at[k]++;
    if (!v && free_bit[k][b]) blocks_at[k]--;
    free_bit[k][b] = v;
  endfunction

  function automatic void zone_reset();
    for (int k = 0; k <= TOP; k++) begin
      blocks_at[k] = 0;
      for (int b = 0; b < ZONE_PAGES; b++) free_bit[k][b] = 1'b0;
    end
    for (int b = 0; b < (ZONE_PAGES >> TOP); b++) mark(TOP, b, 1'b1);
    pages_free = ZONE_PAGES;
    wmark[bpa_pkg::REG_WM_MIN]  = 15'd819;
    wmark[bpa_pkg::REG_WM_LOW]  = 15'd1638;
    wmark[bpa_pkg::REG_WM_HIGH] = 15'd2457;
  endfunction

  function automatic bit hits_free(input int idx, input int ord);
    for (int j = ord; j <= TOP; j++)
      if (free_bit[j][idx >> j]) return 1'b1;
    for (int j = 0; j < ord; j++)
      for (int b = idx >> j; b < ((idx + (1 << ord)) >> j); b++)
        if (free_bit[j][b]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bpa_pkg::rsp_t serve(input bpa_pkg::req_t r);
    bpa_pkg::rsp_t e;
    held_blk_t     hb;
    int            ord, idx, wm, k;
    bit            found;
    ord = int'(r.block_order);
    e.status = bpa_pkg::ST_OK;
    e.block_index = '0;
    found = 1'b0;
    if (ord > TOP) begin
      e.status = bpa_pkg::ST_BAD;
    end else if (r.operation == bpa_pkg::OP_ALLOC) begin
      wm = (r.watermark_class == bpa_pkg::CLS_MIN) ? int'(wmark[bpa_pkg::REG_WM_MIN]) :
           (r.watermark_class == bpa_pkg::CLS_LOW) ? int'(wmark[bpa_pkg::REG_WM_LOW]) :
                                                     int'(wmark[bpa_pkg::REG_WM_HIGH]);
      if (pages_free < wm + (1 << ord)) begin
        e.status = bpa_pkg::ST_LOW;
      end else begin
        for (k = ord; k <= TOP && !found; k++) begin
          if (blocks_at[k] == 0) continue;
          for (int b = 0; b < (ZONE_PAGES >> k) && !found; b++) begin
            if (free_bit[k][b]) begin
              found = 1'b1;
              idx = b << k;
              mark(k, b, 1'b0);
              for (int j = k; j > ord; j--) mark(j - 1, (idx + (1 << (j - 1))) >> (j - 1), 1'b1);
              pages_free -= 1 << ord;
              e.block_index = bpa_pkg::PAGE_BITS'(idx);
              hb.idx = idx;
              hb.ord = ord;
              held.push_back(hb);
            end
          end
        end
        if (!found) e.status = bpa_pkg::ST_NOFREE;
      end
    end else begin
      idx = int'(r.page_index);
      if ((idx & ((1 << ord) - 1)) != 0 || hits_free(idx, ord)) begin
        e.status = bpa_pkg::ST_BAD;
      end else begin
        k = ord;
        while (k < TOP && free_bit[k][(idx ^ (1 << k)) >> k]) begin
          mark(k, (idx ^ (1 << k)) >> k, 1'b0);
          idx &= ~(1 << k);
          k++;
        end
        mark(k, idx >> k, 1'b1);
        pages_free += 1 << ord;
      end
    end
    e.pages_left = pages_free[14:0];
    return e;
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic send(input bpa_pkg::req_t r);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid           <= 1'b1;
    req.operation       <= r.operation;
    req.block_order     <= r.block_order;
    req.page_index      <= r.page_index;
    req.watermark_class <= r.watermark_class;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    board.note(serve(r));
  endtask

  task automatic do_alloc(input int ord, input int cls);
    bpa_pkg::req_t r;
    r.operation = bpa_pkg::OP_ALLOC;
    r.block_order = 4'(ord);
    r.page_index = bpa_pkg::PAGE_BITS'($urandom());
    r.watermark_class = 2'(cls);
    send(r);
  endtask

  task automatic do_free(input int ord, input int idx);
    bpa_pkg::req_t r;
    r.operation = bpa_pkg::OP_FREE;
    r.block_order = 4'(ord);
    r.page_index = bpa_pkg::PAGE_BITS'(idx);
    r.watermark_class = 2'($urandom());
    send(r);
  endtask

  task automatic drain();
    @(posedge clk);
    req.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_marks(input int wmin, input int wlow, input int whigh);
    int vals [3];
    vals = '{wmin, wlow, whigh};
    for (int i = 0; i < 3; i++) begin
      cfg.valid <= 1'b1;
      cfg.index <= 2'(i);
      cfg.data  <= bpa_pkg::CNT_W'(vals[i]);
      @(posedge clk);
      while (!cfg.ready) @(posedge clk);
      wmark[i] = 15'(vals[i]);
    end
    cfg.valid <= 1'b0;
  endtask

  task automatic random_run(input int count);
    held_blk_t h;
    int        pick, ord;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        do_free($urandom_range(0, 15), $urandom());
      end else if (pick < 12 && held.size() > 0) begin
        h = held[$urandom_range(0, held.size() - 1)];
        do_free(h.ord, h.idx);
      end else if (held.size() > 0 && (pick < 50 || pages_free < 3000)) begin
        pick = $urandom_range(0, held.size() - 1);
        h = held[pick];
        held.delete(pick);
        do_free(h.ord, h.idx);
      end else begin
        ord = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 5);
        do_alloc(ord, $urandom_range(0, 3));
      end
    end
  endtask

  // result side: random stalls, in-order check
  initial begin
    int            stall;
    bpa_pkg::rsp_t got;
    rsp.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      got.status = rsp.status;
      got.block_index = rsp.block_index;
      got.pages_left = rsp.pages_left;
      results_seen++;
      status_seen[got.status]++;
      begin
        string msg;
        msg = board.check(got);
        if (msg != "") report(msg);
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    req.valid <= 1'b0;
    req.operation <= bpa_pkg::OP_ALLOC;
    req.block_order <= '0;
    req.page_index <= '0;
    req.watermark_class <= bpa_pkg::CLS_MIN;
    cfg.valid <= 1'b0;
    cfg.index <= bpa_pkg::REG_WM_MIN;
    cfg.data <= '0;
    zone_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset watermarks first
    do_alloc(11, 0);
    do_alloc(15, 2);
    do_alloc(0, 0);
    do_alloc(0, 3);
    do_free(0, 0);
    do_free(3, 5);
    do_free(0, 0);
    drain();
    set_marks(0, 0, 0);
    // take every free top-order block, then leave two unpaired halves: enough pages, no block
    for (int i = 0; i < 15; i++) do_alloc(10, 1);
    do_alloc(10, 2);
    do_free(9, 14 * 1024);
    do_free(9, 15 * 1024 + 512);
    do_alloc(10, 0);
    do_free(13, 8191);
    random_run(120);
    drain();

    set_marks(16384, 16384, 16384);
    random_run(80);
    drain();

    set_marks(200, 1500, 6000);
    random_run(200);
    drain();

    set_marks($urandom_range(0, 16384), $urandom_range(0, 16384), $urandom_range(0, 4000));
    random_run(150);
    drain();

    set_marks(0, 16384, 0);
    random_run(200);
    drain();

    $display("Covered %0d results: %0d done, %0d below watermark, %0d no block, %0d bad.",
             results_seen, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    $display("Five watermark settings, %0d blocks still held at the end.", held.size());
    if (mismatches == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (board.pending.size() != 0) report("predicted results left over");
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
